/* rtl/core/otsu_pkg.sv */
`timescale 1ns / 1ps

package otsu_pkg;

    localparam int unsigned LEVEL_W   = 8;
    localparam int unsigned LEVELS    = 256;
    localparam int unsigned CNT_W     = 17;
    localparam int unsigned SUM_W     = 24;
    localparam int unsigned FRAC_W    = 16;
    localparam int unsigned DVD_W     = SUM_W + FRAC_W;
    localparam int unsigned QUO_W     = 24;
    localparam int unsigned STEP_W    = 6;
    localparam int unsigned WSH       = 4;
    localparam int unsigned WT_W      = CNT_W - WSH;
    localparam int unsigned SQ_W      = 24;
    localparam int unsigned P1_W      = SQ_W + WT_W;
    localparam int unsigned SCORE_W   = P1_W + WT_W;
    localparam int unsigned MAX_PIXELS = 65536;

    typedef struct packed {
        logic               acc_v;
        logic [LEVEL_W-1:0] acc_px;
        logic               swp_rd;
        logic               clr;
        logic [LEVEL_W-1:0] swp_addr;
    } t_hist_req;

endpackage

/* rtl/core/otsu_hist.sv */
`timescale 1ns / 1ps

module otsu_hist (
    input  logic                                    i_clk,
    input  otsu_pkg::t_hist_req                     i_req,
    output logic [otsu_pkg::CNT_W-1:0]              o_rd_data
);

    logic [otsu_pkg::CNT_W-1:0]   mem [otsu_pkg::LEVELS];
    logic [otsu_pkg::CNT_W-1:0]   r_rd;
    logic                         r_s1_v;
    logic [otsu_pkg::LEVEL_W-1:0] r_s1_addr;
    logic                         r_fwd_v;
    logic [otsu_pkg::LEVEL_W-1:0] r_fwd_addr;
    logic [otsu_pkg::CNT_W-1:0]   r_fwd_val;
    logic [otsu_pkg::CNT_W-1:0]   cur;
    logic [otsu_pkg::CNT_W-1:0]   inc;
    logic [otsu_pkg::LEVEL_W-1:0] rd_addr;
    logic                         we;
    logic [otsu_pkg::LEVEL_W-1:0] wa;
    logic [otsu_pkg::CNT_W-1:0]   wd;

    // the bin written last cycle was read before that write landed
    assign cur = (r_fwd_v && (r_fwd_addr == r_s1_addr)) ? r_fwd_val : r_rd;
    assign inc = cur + otsu_pkg::CNT_W'(1);
    assign rd_addr = i_req.swp_rd ? i_req.swp_addr : i_req.acc_px;

    always_comb begin
        we = 1'b0;
        wa = i_req.swp_addr;
        wd = '0;
        if (r_s1_v) begin
            we = 1'b1;
            wa = r_s1_addr;
            wd = inc;
        end else if (i_req.clr) begin
            we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        r_rd <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        r_s1_v     <= i_req.acc_v;
        r_s1_addr  <= i_req.acc_px;
        r_fwd_v    <= r_s1_v;
        r_fwd_addr <= r_s1_addr;
        r_fwd_val  <= inc;
    end

    assign o_rd_data = r_rd;

endmodule

/* rtl/core/otsu_div.sv */
`timescale 1ns / 1ps

module otsu_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [otsu_pkg::DVD_W-1:0]      i_dividend,
    input  logic [otsu_pkg::CNT_W-1:0]      i_divisor,
    output logic                            o_busy,
    output logic [otsu_pkg::QUO_W-1:0]      o_quot
);

    logic [otsu_pkg::STEP_W-1:0] r_cnt;
    logic [otsu_pkg::DVD_W-1:0]  r_dvd;
    logic [otsu_pkg::CNT_W-1:0]  r_div;
    logic [otsu_pkg::CNT_W-1:0]  r_rem;
    logic [otsu_pkg::QUO_W-1:0]  r_quot;
    logic [otsu_pkg::CNT_W:0]    rem_sh;
    logic                        ge;

    // one quotient bit per cycle, restoring
    assign rem_sh = {r_rem, r_dvd[otsu_pkg::DVD_W-1]};
    assign ge     = rem_sh >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= otsu_pkg::STEP_W'(otsu_pkg::DVD_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - otsu_pkg::STEP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd  <= i_dividend;
            r_div  <= i_divisor;
            r_rem  <= '0;
            r_quot <= '0;
        end else if (r_cnt != '0) begin
            r_dvd  <= {r_dvd[otsu_pkg::DVD_W-2:0], 1'b0};
            r_rem  <= ge ? otsu_pkg::CNT_W'(rem_sh - {1'b0, r_div})
                         : rem_sh[otsu_pkg::CNT_W-1:0];
            r_quot <= {r_quot[otsu_pkg::QUO_W-2:0], ge};
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quot = r_quot;

endmodule

/* rtl/core/otsu_threshold_engine.sv */
`timescale 1ns / 1ps

// pixel stream in on the s channel: tdata is the 8-bit grey level, tlast marks
// the final pixel of an image. one pixel is taken per cycle while accumulating;
// each pixel updates its bin in the histogram ram through a read-modify-write
// pipe with forwarding, so runs of equal levels stream at full rate.
// pixels beyond 65536 in one image are dropped and flagged.
// after the last pixel the input stalls while the search sweeps the bins, up to
// all 256; it stops once no pixel lies above the current level. each level with
// pixels on both sides runs two 40-step dividers in parallel, then square and
// two weight products; levels below the lowest filled bin skip the dividers.
// the search clears each bin as it reads it, and the result (tdata threshold,
// tuser overflow) is held in an output register until the m channel takes it;
// the next image is accepted while it waits. a second result waits in the
// search until that register is free.
// after reset the block zeroes every bin of the ram before it accepts any pixel.
module otsu_threshold_engine (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] pixel
    input  logic       i_s_tlast,
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] threshold
    output logic       o_m_tuser    // [0] overflow
);

    typedef enum logic [10:0] {
        ST_INIT  = 11'b000_0000_0001,
        ST_ACC   = 11'b000_0000_0010,
        ST_DRAIN = 11'b000_0000_0100,
        ST_READ  = 11'b000_0000_1000,
        ST_DATA  = 11'b000_0001_0000,
        ST_DIV   = 11'b000_0010_0000,
        ST_SQ    = 11'b000_0100_0000,
        ST_M1    = 11'b000_1000_0000,
        ST_M2    = 11'b001_0000_0000,
        ST_CMP   = 11'b010_0000_0000,
        ST_DONE  = 11'b100_0000_0000
    } t_state;

    t_state                                  r_state;
    logic [otsu_pkg::LEVEL_W-1:0]            r_t;
    logic [otsu_pkg::CNT_W-1:0]              r_total;
    logic [otsu_pkg::SUM_W-1:0]              r_sum;
    logic                                    r_ovf;
    logic [otsu_pkg::CNT_W-1:0]              r_wb;
    logic [otsu_pkg::CNT_W-1:0]              r_wf;
    logic [otsu_pkg::SUM_W-1:0]              r_sb;
    logic [otsu_pkg::SQ_W-1:0]               r_sq;
    logic [otsu_pkg::P1_W-1:0]               r_p1;
    logic [otsu_pkg::SCORE_W-1:0]            r_score;
    logic [otsu_pkg::SCORE_W-1:0]            r_best;
    logic [otsu_pkg::LEVEL_W-1:0]            r_thr;
    logic                                    r_m_valid;
    logic [7:0]                              r_m_thr;
    logic                                    r_m_ovf;

    otsu_pkg::t_hist_req                     req;
    logic [otsu_pkg::CNT_W-1:0]              h;
    logic                                    s_acc;
    logic                                    counted;
    logic [otsu_pkg::CNT_W-1:0]              n_wb;
    logic [otsu_pkg::CNT_W-1:0]              n_wf;
    logic [otsu_pkg::SUM_W-1:0]              n_sb;
    logic [otsu_pkg::SUM_W:0]                prod;
    logic                                    div_start;
    logic                                    busy_b;
    logic                                    busy_f;
    logic [otsu_pkg::QUO_W-1:0]              mb;
    logic [otsu_pkg::QUO_W-1:0]              mf;
    logic [otsu_pkg::QUO_W-1:0]              d;
    logic [15:0]                             dh;
    logic [31:0]                             dsq;

    assign o_s_tready = (r_state == ST_ACC);
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign counted    = r_total < otsu_pkg::CNT_W'(otsu_pkg::MAX_PIXELS);

    always_comb begin
        req.acc_v    = s_acc && counted;
        req.acc_px   = i_s_tdata;
        req.swp_rd   = (r_state == ST_READ);
        req.clr      = (r_state == ST_INIT) || (r_state == ST_DATA);
        req.swp_addr = r_t;
    end

    otsu_hist u_hist (
        .i_clk     (i_clk),
        .i_req     (req),
        .o_rd_data (h)
    );

    assign prod = (otsu_pkg::SUM_W + 1)'(r_t) * (otsu_pkg::SUM_W + 1)'(h);
    assign n_wb = r_wb + h;
    assign n_wf = r_total - n_wb;
    assign n_sb = r_sb + prod[otsu_pkg::SUM_W-1:0];
    assign div_start = (r_state == ST_DATA) && (n_wb != '0) && (n_wf != '0);

    otsu_div u_div_b (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend ({n_sb, otsu_pkg::FRAC_W'(0)}),
        .i_divisor  (n_wb),
        .o_busy     (busy_b),
        .o_quot     (mb)
    );

    otsu_div u_div_f (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend ({r_sum - n_sb, otsu_pkg::FRAC_W'(0)}),
        .i_divisor  (n_wf),
        .o_busy     (busy_f),
        .o_quot     (mf)
    );

    assign d   = (mb > mf) ? (mb - mf) : (mf - mb);
    assign dh  = d[otsu_pkg::QUO_W-1:8];
    assign dsq = dh * dh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_INIT;
            r_t       <= '0;
            r_total   <= '0;
            r_sum     <= '0;
            r_ovf     <= 1'b0;
            r_wb      <= '0;
            r_sb      <= '0;
            r_best    <= '0;
            r_thr     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            // a new result loaded in the done state takes precedence
            if (r_m_valid && i_m_tready && (r_state != ST_DONE)) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                ST_INIT: begin
                    r_t <= r_t + otsu_pkg::LEVEL_W'(1);
                    if (r_t == '1) begin
                        r_state <= ST_ACC;
                    end
                end
                ST_ACC: begin
                    if (s_acc) begin
                        if (counted) begin
                            r_total <= r_total + otsu_pkg::CNT_W'(1);
                            r_sum   <= r_sum + otsu_pkg::SUM_W'(i_s_tdata);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (i_s_tlast) begin
                            r_state <= ST_DRAIN;
                        end
                    end
                end
                ST_DRAIN: begin
                    r_state <= ST_READ;
                end
                ST_READ: begin
                    r_state <= ST_DATA;
                end
                ST_DATA: begin
                    r_wb <= n_wb;
                    r_wf <= n_wf;
                    r_sb <= n_sb;
                    if (n_wb == '0) begin
                        r_t     <= r_t + otsu_pkg::LEVEL_W'(1);
                        r_state <= (r_t == '1) ? ST_DONE : ST_READ;
                    end else if (n_wf == '0) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (!busy_b && !busy_f) begin
                        r_state <= ST_SQ;
                    end
                end
                ST_SQ: begin
                    r_state <= ST_M1;
                end
                ST_M1: begin
                    r_state <= ST_M2;
                end
                ST_M2: begin
                    r_state <= ST_CMP;
                end
                ST_CMP: begin
                    if (r_score > r_best) begin
                        r_best <= r_score;
                        r_thr  <= r_t;
                    end
                    r_t     <= r_t + otsu_pkg::LEVEL_W'(1);
                    r_state <= (r_t == '1) ? ST_DONE : ST_READ;
                end
                ST_DONE: begin
                    if (!r_m_valid || i_m_tready) begin
                        r_m_valid <= 1'b1;
                        r_t       <= '0;
                        r_total   <= '0;
                        r_sum     <= '0;
                        r_ovf     <= 1'b0;
                        r_wb      <= '0;
                        r_sb      <= '0;
                        r_best    <= '0;
                        r_thr     <= '0;
                        r_state   <= ST_ACC;
                    end
                end
                default: begin
                    r_state <= ST_INIT;
                end
            endcase
        end
    end

    // arithmetic pipe of the score, one product per stage, and the result output register
    always_ff @(posedge i_clk) begin
        r_sq    <= dsq[31:8];
        r_p1    <= otsu_pkg::P1_W'(r_sq) * otsu_pkg::P1_W'(r_wb[otsu_pkg::CNT_W-1:otsu_pkg::WSH]);
        r_score <= otsu_pkg::SCORE_W'(r_p1)
                 * otsu_pkg::SCORE_W'(r_wf[otsu_pkg::CNT_W-1:otsu_pkg::WSH]);
        if ((r_state == ST_DONE) && (!r_m_valid || i_m_tready)) begin
            r_m_thr <= r_thr;
            r_m_ovf <= r_ovf;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_thr;
    assign o_m_tuser  = r_m_ovf;

endmodule
